// ===== rtl/core/pitt_pkg.sv =====
package pitt_pkg;

	// Coordinate width of the incoming points
	localparam int COORD_BITS = 16;
	// Difference of two coordinates
	localparam int DIFF_W = COORD_BITS + 1;
	// One cross product component
	localparam int CROSS_W = 2 * DIFF_W + 1;
	// Split of a cross component into a signed high part and an unsigned low part
	localparam int LO_W = CROSS_W / 2 + 1;
	localparam int HI_W = CROSS_W - LO_W;
	// Partial product widths
	localparam int HH_W = 2 * HI_W;
	localparam int MIX_W = HI_W + LO_W + 1;
	localparam int LL_W = 2 * LO_W;
	// Full product of two cross components and the three-term dot sum
	localparam int PROD_W = 2 * CROSS_W;
	localparam int DOT_W = PROD_W + 2;
	// Plane test: offset times normal component, and its three-term sum
	localparam int PH_W = DIFF_W + HI_W;
	localparam int PL_W = DIFF_W + LO_W + 1;
	localparam int PLANE_W = DIFF_W + CROSS_W;
	localparam int PDOT_W = PLANE_W + 2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [CROSS_W-1:0] cross_t;

	// Per-stage load enables shared by the pipeline sections
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} adv_t;

	// Sign-extend and subtract two coordinates
	function automatic diff_t coord_diff(coord_t a, coord_t b);
		diff_t xa;
		diff_t xb;
		xa = {a[COORD_BITS-1], a};
		xb = {b[COORD_BITS-1], b};
		return xa - xb;
	endfunction

	// a*b - c*d, full width
	function automatic cross_t cross_term(diff_t a, diff_t b, diff_t c, diff_t d);
		logic signed [2*DIFF_W-1:0] p;
		logic signed [2*DIFF_W-1:0] m;
		p = a * b;
		m = c * d;
		return CROSS_W'(p) - CROSS_W'(m);
	endfunction

endpackage

// ===== rtl/core/pitt_if.sv =====
interface pitt_in_if;
	logic valid;
	logic ready;
	logic signed [pitt_pkg::COORD_BITS-1:0] point_x;
	logic signed [pitt_pkg::COORD_BITS-1:0] point_y;
	logic signed [pitt_pkg::COORD_BITS-1:0] point_z;
	logic signed [pitt_pkg::COORD_BITS-1:0] vert_a_x;
	logic signed [pitt_pkg::COORD_BITS-1:0] vert_a_y;
	logic signed [pitt_pkg::COORD_BITS-1:0] vert_a_z;
	logic signed [pitt_pkg::COORD_BITS-1:0] vert_b_x;
	logic signed [pitt_pkg::COORD_BITS-1:0] vert_b_y;
	logic signed [pitt_pkg::COORD_BITS-1:0] vert_b_z;
	logic signed [pitt_pkg::COORD_BITS-1:0] vert_c_x;
	logic signed [pitt_pkg::COORD_BITS-1:0] vert_c_y;
	logic signed [pitt_pkg::COORD_BITS-1:0] vert_c_z;

	modport source (
		output valid, point_x, point_y, point_z,
		output vert_a_x, vert_a_y, vert_a_z,
		output vert_b_x, vert_b_y, vert_b_z,
		output vert_c_x, vert_c_y, vert_c_z,
		input ready
	);
	modport sink (
		input valid, point_x, point_y, point_z,
		input vert_a_x, vert_a_y, vert_a_z,
		input vert_b_x, vert_b_y, vert_b_z,
		input vert_c_x, vert_c_y, vert_c_z,
		output ready
	);
endinterface

interface pitt_out_if;
	logic valid;
	logic ready;
	logic inside_res;
	logic within_prism;

	modport source (output valid, inside_res, within_prism, input ready);
	modport sink (input valid, inside_res, within_prism, output ready);
endinterface

// ===== rtl/core/pitt_side_test.sv =====
module pitt_side_test (
	input logic clk,
	input pitt_pkg::adv_t adv,
	input pitt_pkg::coord_t q [3],
	input pitt_pkg::coord_t r [3],
	input pitt_pkg::coord_t e0 [3],
	input pitt_pkg::coord_t e1 [3],
	output pitt_pkg::cross_t k2 [3],
	output logic pass
);
	import pitt_pkg::*;

	diff_t edge_s1 [3];
	diff_t dq_s1 [3];
	diff_t dr_s1 [3];
	cross_t k1_s2 [3];
	cross_t k2_s2 [3];
	logic signed [HH_W-1:0] hh_s3 [3];
	logic signed [MIX_W-1:0] hl_s3 [3];
	logic signed [MIX_W-1:0] lh_s3 [3];
	logic [LL_W-1:0] ll_s3 [3];
	logic signed [PROD_W-1:0] prod_s4 [3];

	logic signed [HI_W-1:0] a_hi [3];
	logic signed [HI_W-1:0] b_hi [3];
	logic [LO_W-1:0] a_lo [3];
	logic [LO_W-1:0] b_lo [3];
	logic signed [DOT_W-1:0] dot;

	// Stage 1: edge and the two offsets from the edge start
	always_ff @(posedge clk) begin
		if (adv.en_s1) begin
			for (int i = 0; i < 3; i++) begin
				edge_s1[i] <= coord_diff(e1[i], e0[i]);
				dq_s1[i] <= coord_diff(q[i], e0[i]);
				dr_s1[i] <= coord_diff(r[i], e0[i]);
			end
		end
	end

	// Stage 2: both cross products with the edge
	always_ff @(posedge clk) begin
		if (adv.en_s2) begin
			k1_s2[0] <= cross_term(edge_s1[1], dq_s1[2], edge_s1[2], dq_s1[1]);
			k1_s2[1] <= cross_term(edge_s1[2], dq_s1[0], edge_s1[0], dq_s1[2]);
			k1_s2[2] <= cross_term(edge_s1[0], dq_s1[1], edge_s1[1], dq_s1[0]);
			k2_s2[0] <= cross_term(edge_s1[1], dr_s1[2], edge_s1[2], dr_s1[1]);
			k2_s2[1] <= cross_term(edge_s1[2], dr_s1[0], edge_s1[0], dr_s1[2]);
			k2_s2[2] <= cross_term(edge_s1[0], dr_s1[1], edge_s1[1], dr_s1[0]);
		end
	end

	assign k2 = k2_s2;

	// Split each cross component into high and low halves
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a_hi[i] = k1_s2[i][CROSS_W-1:LO_W];
			a_lo[i] = k1_s2[i][LO_W-1:0];
			b_hi[i] = k2_s2[i][CROSS_W-1:LO_W];
			b_lo[i] = k2_s2[i][LO_W-1:0];
		end
	end

	// Stage 3: four partial products per component
	always_ff @(posedge clk) begin
		if (adv.en_s3) begin
			for (int i = 0; i < 3; i++) begin
				hh_s3[i] <= a_hi[i] * b_hi[i];
				hl_s3[i] <= a_hi[i] * $signed({1'b0, b_lo[i]});
				lh_s3[i] <= $signed({1'b0, a_lo[i]}) * b_hi[i];
				ll_s3[i] <= a_lo[i] * b_lo[i];
			end
		end
	end

	// Stage 4: recombine the partials into full component products
	always_ff @(posedge clk) begin
		if (adv.en_s4) begin
			for (int i = 0; i < 3; i++) begin
				prod_s4[i] <= (PROD_W'(hh_s3[i]) <<< (2 * LO_W))
					+ ((PROD_W'(hl_s3[i]) + PROD_W'(lh_s3[i])) <<< LO_W)
					+ $signed(PROD_W'(ll_s3[i]));
			end
		end
	end

	// Sum the dot product and test its sign
	always_comb begin
		dot = DOT_W'(prod_s4[0]) + DOT_W'(prod_s4[1]) + DOT_W'(prod_s4[2]);
		pass = !dot[DOT_W-1];
	end

endmodule

// ===== rtl/core/point_in_triangle_3d_test.sv =====
// Five register stages, s1 to s5; a result is offered from the s5 register and
// transfers when res_out.ready is high.
// Throughput: one item per cycle while the result side does not stall; the pipeline holds up to five items and
// each stage loads whenever it is empty or the stage after it advances.
// The deepest stage is the cross product: a 17 x 17 product and a 35-bit subtract.
// Reset (arst_n low) clears all stage valid bits; no results are pending after.
module point_in_triangle_3d_test (
	input logic clk,
	input logic arst_n,
	pitt_in_if.sink pt_in,
	pitt_out_if.source res_out
);
	import pitt_pkg::*;

	adv_t adv;
	logic en_s5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	coord_t p_v [3];
	coord_t a_v [3];
	coord_t b_v [3];
	coord_t c_v [3];

	cross_t k2_bc [3];
	cross_t k2_ac [3];
	cross_t nrm [3];
	logic [2:0] pass;

	diff_t dpa_s1 [3];
	diff_t dpa_s2 [3];
	logic signed [PH_W-1:0] ph_s3 [3];
	logic signed [PL_W-1:0] pl_s3 [3];
	logic nz_s3;
	logic signed [PLANE_W-1:0] pprod_s4 [3];
	logic nz_s4;
	logic inside_s5;
	logic within_s5;

	logic signed [HI_W-1:0] n_hi [3];
	logic [LO_W-1:0] n_lo [3];
	logic signed [PDOT_W-1:0] psum;

	// Gather the vertex fields into vectors
	always_comb begin
		p_v[0] = pt_in.point_x;
		p_v[1] = pt_in.point_y;
		p_v[2] = pt_in.point_z;
		a_v[0] = pt_in.vert_a_x;
		a_v[1] = pt_in.vert_a_y;
		a_v[2] = pt_in.vert_a_z;
		b_v[0] = pt_in.vert_b_x;
		b_v[1] = pt_in.vert_b_y;
		b_v[2] = pt_in.vert_b_z;
		c_v[0] = pt_in.vert_c_x;
		c_v[1] = pt_in.vert_c_y;
		c_v[2] = pt_in.vert_c_z;
	end

	// Advance a stage when it is empty or its successor advances
	always_comb begin
		en_s5 = !v_s5 || res_out.ready;
		adv.en_s4 = !v_s4 || en_s5;
		adv.en_s3 = !v_s3 || adv.en_s4;
		adv.en_s2 = !v_s2 || adv.en_s3;
		adv.en_s1 = !v_s1 || adv.en_s2;
	end

	assign pt_in.ready = adv.en_s1;

	// Move valid bits along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv.en_s1) v_s1 <= pt_in.valid;
			if (adv.en_s2) v_s2 <= v_s1;
			if (adv.en_s3) v_s3 <= v_s2;
			if (adv.en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// Edge B..C against A
	pitt_side_test u_side_bc (
		.clk(clk), .adv(adv),
		.q(p_v), .r(a_v), .e0(b_v), .e1(c_v),
		.k2(k2_bc), .pass(pass[0])
	);

	// Edge A..C against B
	pitt_side_test u_side_ac (
		.clk(clk), .adv(adv),
		.q(p_v), .r(b_v), .e0(a_v), .e1(c_v),
		.k2(k2_ac), .pass(pass[1])
	);

	// Edge A..B against C; its second cross is the triangle normal
	pitt_side_test u_side_ab (
		.clk(clk), .adv(adv),
		.q(p_v), .r(c_v), .e0(a_v), .e1(b_v),
		.k2(nrm), .pass(pass[2])
	);

	// Plane offset P - A, held alongside the cross stage
	always_ff @(posedge clk) begin
		if (adv.en_s1) begin
			for (int i = 0; i < 3; i++) dpa_s1[i] <= coord_diff(p_v[i], a_v[i]);
		end
		if (adv.en_s2) begin
			dpa_s2 <= dpa_s1;
		end
	end

	// Split the normal into high and low halves
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n_hi[i] = nrm[i][CROSS_W-1:LO_W];
			n_lo[i] = nrm[i][LO_W-1:0];
		end
	end

	// Plane partial products and the zero-normal check
	always_ff @(posedge clk) begin
		if (adv.en_s3) begin
			for (int i = 0; i < 3; i++) begin
				ph_s3[i] <= dpa_s2[i] * n_hi[i];
				pl_s3[i] <= dpa_s2[i] * $signed({1'b0, n_lo[i]});
			end
			nz_s3 <= (nrm[0] != '0) || (nrm[1] != '0) || (nrm[2] != '0);
		end
	end

	// Recombine plane products
	always_ff @(posedge clk) begin
		if (adv.en_s4) begin
			for (int i = 0; i < 3; i++) begin
				pprod_s4[i] <= (PLANE_W'(ph_s3[i]) <<< LO_W) + PLANE_W'(pl_s3[i]);
			end
			nz_s4 <= nz_s3;
		end
	end

	assign psum = PDOT_W'(pprod_s4[0]) + PDOT_W'(pprod_s4[1]) + PDOT_W'(pprod_s4[2]);

	// Final flags, held until the result transfer
	always_ff @(posedge clk) begin
		if (en_s5) begin
			within_s5 <= &pass;
			inside_s5 <= (&pass) && nz_s4 && (psum == '0);
		end
	end

	assign res_out.valid = v_s5;
	assign res_out.inside_res = inside_s5;
	assign res_out.within_prism = within_s5;

endmodule

// ===== dv/tb_point_in_triangle_3d_test.sv =====
`timescale 1ns / 1ps

module tb_point_in_triangle_3d_test;
	import pitt_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 12;
	localparam int RANDOM_QUERIES = 900;

	typedef logic signed [159:0] wide_t;
	typedef struct packed {
		wide_t x;
		wide_t y;
		wide_t z;
	} vec_t;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		coord_t point_z;
		coord_t vert_a_x;
		coord_t vert_a_y;
		coord_t vert_a_z;
		coord_t vert_b_x;
		coord_t vert_b_y;
		coord_t vert_b_z;
		coord_t vert_c_x;
		coord_t vert_c_y;
		coord_t vert_c_z;
	} query_t;

	typedef struct packed {
		logic inside_res;
		logic within_prism;
	} flags_t;

	// Exact containment predictor and the store of flags still owed by the block
	class containment_sb;
		flags_t pending[$];
		int unsigned n_queries;
		int unsigned n_results;
		int unsigned n_inside;
		int unsigned n_prism;
		int unsigned n_errors;

		function vec_t widen(coord_t x, coord_t y, coord_t z);
			vec_t r;
			r.x = x;
			r.y = y;
			r.z = z;
			return r;
		endfunction

		function vec_t vec_minus(vec_t a, vec_t b);
			vec_t r;
			r.x = a.x - b.x;
			r.y = a.y - b.y;
			r.z = a.z - b.z;
			return r;
		endfunction

		function vec_t vec_cross(vec_t u, vec_t v);
			vec_t r;
			r.x = u.y * v.z - u.z * v.y;
			r.y = u.z * v.x - u.x * v.z;
			r.z = u.x * v.y - u.y * v.x;
			return r;
		endfunction

		function wide_t vec_dot(vec_t u, vec_t v);
			return u.x * v.x + u.y * v.y + u.z * v.z;
		endfunction

		// q and r on the same side of the line e0..e1, or on it
		function bit same_side(vec_t q, vec_t r, vec_t e0, vec_t e1);
			vec_t edge_v;
			wide_t d;
			edge_v = vec_minus(e1, e0);
			d = vec_dot(vec_cross(edge_v, vec_minus(q, e0)), vec_cross(edge_v, vec_minus(r, e0)));
			return d >= 0;
		endfunction

		function flags_t predict_containment(query_t q);
			vec_t p;
			vec_t a;
			vec_t b;
			vec_t c;
			vec_t nrm;
			flags_t f;
			p = widen(q.point_x, q.point_y, q.point_z);
			a = widen(q.vert_a_x, q.vert_a_y, q.vert_a_z);
			b = widen(q.vert_b_x, q.vert_b_y, q.vert_b_z);
			c = widen(q.vert_c_x, q.vert_c_y, q.vert_c_z);
			f.within_prism = same_side(p, a, b, c) && same_side(p, b, a, c)
				&& same_side(p, c, a, b);
			f.inside_res = 1'b0;
			// In the plane only counts for a non-degenerate triangle
			if (f.within_prism) begin
				nrm = vec_cross(vec_minus(b, a), vec_minus(c, a));
				if (nrm != '0)
					f.inside_res = vec_dot(vec_minus(p, a), nrm) == 0;
			end
			return f;
		endfunction

		function void note_query(query_t q);
			pending.push_back(predict_containment(q));
			n_queries++;
		endfunction

		function void check_result(logic inside_res, logic within_prism);
			flags_t exp_f;
			n_results++;
			if (inside_res === 1'b1)
				n_inside++;
			if (within_prism === 1'b1)
				n_prism++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result inside_res=%b within_prism=%b",
					$time, inside_res, within_prism);
				n_errors++;
				return;
			end
			exp_f = pending.pop_front();
			if (inside_res !== exp_f.inside_res) begin
				$display("%0t: inside_res mismatch, expected %b actual %b",
					$time, exp_f.inside_res, inside_res);
				n_errors++;
			end
			if (within_prism !== exp_f.within_prism) begin
				$display("%0t: within_prism mismatch, expected %b actual %b",
					$time, exp_f.within_prism, within_prism);
				n_errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int unsigned cycle_count = 0;
	int unsigned src_gap_max = 3;
	int unsigned sink_stall_max = 3;
	containment_sb sb;

	pitt_in_if pt_in ();
	pitt_out_if res_out ();

	point_in_triangle_3d_test i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pt_in(pt_in),
		.res_out(res_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results owed", cycle_count,
				sb.pending.size());
			$display("[point_in_triangle_3d_test] ERROR");
			$finish;
		end
	end

	function automatic query_t make_query(int px, int py, int pz, int ax, int ay, int az,
		int bx, int by, int bz, int cx, int cy, int cz);
		query_t q;
		q.point_x = coord_t'(px);
		q.point_y = coord_t'(py);
		q.point_z = coord_t'(pz);
		q.vert_a_x = coord_t'(ax);
		q.vert_a_y = coord_t'(ay);
		q.vert_a_z = coord_t'(az);
		q.vert_b_x = coord_t'(bx);
		q.vert_b_y = coord_t'(by);
		q.vert_b_z = coord_t'(bz);
		q.vert_c_x = coord_t'(cx);
		q.vert_c_y = coord_t'(cy);
		q.vert_c_z = coord_t'(cz);
		return q;
	endfunction

	function automatic int any_coord();
		case ($urandom_range(7, 0))
			0: return -32768;
			1: return 32767;
			2: return 0;
			default: return int'($urandom_range(65535, 0)) - 32768;
		endcase
	endfunction

	function automatic int small_step();
		return int'($urandom_range(128, 0)) - 64;
	endfunction

	function automatic int near_coord();
		return int'($urandom_range(32000, 0)) - 16000;
	endfunction

	// Triangle spanned by two small steps from A; the point lies in its plane
	// unless tilted, and lands inside, on the border or just outside
	function automatic query_t planar_query(bit tilt, bit collinear);
		int a[3];
		int u[3];
		int v[3];
		int p[3];
		int m_b;
		int m_c;
		int s;
		int t;
		m_b = $urandom_range(8, 1);
		m_c = $urandom_range(8, 1);
		s = int'($urandom_range(m_b + 1, 0)) - 1;
		t = int'($urandom_range(m_c + 1, 0)) - 1;
		for (int k = 0; k < 3; k++) begin
			a[k] = near_coord();
			u[k] = small_step();
			v[k] = collinear ? u[k] : small_step();
		end
		for (int k = 0; k < 3; k++)
			p[k] = a[k] + s * u[k] + t * v[k];
		if (tilt)
			p[$urandom_range(2, 0)] += int'($urandom_range(6, 0)) - 3;
		return make_query(p[0], p[1], p[2], a[0], a[1], a[2],
			a[0] + m_b * u[0], a[1] + m_b * u[1], a[2] + m_b * u[2],
			a[0] + m_c * v[0], a[1] + m_c * v[1], a[2] + m_c * v[2]);
	endfunction

	// Offer one query and hold it until the block takes it
	task automatic send_query(input query_t q);
		int unsigned gap;
		gap = $urandom_range(src_gap_max, 0);
		repeat (gap) begin
			@(negedge clk);
			pt_in.valid = 1'b0;
		end
		@(negedge clk);
		pt_in.valid = 1'b1;
		pt_in.point_x = q.point_x;
		pt_in.point_y = q.point_y;
		pt_in.point_z = q.point_z;
		pt_in.vert_a_x = q.vert_a_x;
		pt_in.vert_a_y = q.vert_a_y;
		pt_in.vert_a_z = q.vert_a_z;
		pt_in.vert_b_x = q.vert_b_x;
		pt_in.vert_b_y = q.vert_b_y;
		pt_in.vert_b_z = q.vert_b_z;
		pt_in.vert_c_x = q.vert_c_x;
		pt_in.vert_c_y = q.vert_c_y;
		pt_in.vert_c_z = q.vert_c_z;
		do @(posedge clk); while (!pt_in.ready);
		sb.note_query(q);
	endtask

	// Result side: stall at random, check every transfer
	initial begin
		int unsigned stall;
		res_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(sink_stall_max, 0);
			repeat (stall) begin
				@(negedge clk);
				res_out.ready = 1'b0;
			end
			@(negedge clk);
			res_out.ready = 1'b1;
			do @(posedge clk); while (!res_out.valid);
			sb.check_result(res_out.inside_res, res_out.within_prism);
		end
	end

	initial begin
		int kind;
		sb = new();
		arst_n = 1'b0;
		pt_in.valid = 1'b0;
		{pt_in.point_x, pt_in.point_y, pt_in.point_z} = '0;
		{pt_in.vert_a_x, pt_in.vert_a_y, pt_in.vert_a_z} = '0;
		{pt_in.vert_b_x, pt_in.vert_b_y, pt_in.vert_b_z} = '0;
		{pt_in.vert_c_x, pt_in.vert_c_y, pt_in.vert_c_z} = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed: degenerate triangles, vertex, edge, interior, off plane, extremes
		send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_query(make_query(0, 0, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		send_query(make_query(100, 0, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		send_query(make_query(50, 0, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		send_query(make_query(50, 50, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		send_query(make_query(10, 10, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		send_query(make_query(10, 10, 5, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		send_query(make_query(10, 10, -32768, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		send_query(make_query(200, 200, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		send_query(make_query(-1, 10, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		send_query(make_query(51, 50, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		send_query(make_query(2, 2, 4, 0, 0, 0, 6, 0, 6, 0, 6, 6));
		send_query(make_query(2, 2, 5, 0, 0, 0, 6, 0, 6, 0, 6, 6));
		send_query(make_query(5, 5, 5, 0, 0, 0, 1, 1, 1, 2, 2, 2));
		send_query(make_query(7, 1, 3, 0, 0, 0, 1, 1, 1, 2, 2, 2));
		send_query(make_query(3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3));
		send_query(make_query(32767, 32767, 32767, 32767, 32767, 32767,
			32767, 32767, 32767, 32767, 32767, 32767));
		send_query(make_query(-32768, -32768, -32768, -32768, -32768, -32768,
			-32768, -32768, -32768, -32768, -32768, -32768));
		send_query(make_query(-32768, -32768, -32768, -32768, -32768, -32768,
			32767, -32768, -32768, -32768, 32767, 32767));
		send_query(make_query(32767, 32767, -32768, -32768, -32768, -32768,
			32767, -32768, -32768, -32768, 32767, 32767));
		send_query(make_query(32767, -32768, 32767, -32768, 32767, -32768,
			32767, 32767, -32768, -32768, -32768, 32767));
		send_query(make_query(0, -32768, -32768, -32768, 32767, 32767,
			32767, 32767, 32767, 32767, -32768, -32768));
		send_query(make_query(16'sh5555, 16'sh5555, 16'sh5555, -21846, -21846, -21846,
			16'sh5555, -21846, 16'sh5555, -21846, 16'sh5555, 16'sh5555));

		// Random: mostly planar triangles, some tilted or collinear, rest noise
		for (int i = 0; i < RANDOM_QUERIES; i++) begin
			if (i == 300) begin
				src_gap_max = 0;
				sink_stall_max = 0;
			end else if (i == 450) begin
				src_gap_max = 3;
				sink_stall_max = 3;
			end
			kind = $urandom_range(19, 0);
			if (kind < 10)
				send_query(planar_query(1'b0, 1'b0));
			else if (kind < 13)
				send_query(planar_query(1'b1, 1'b0));
			else if (kind < 15)
				send_query(planar_query(1'b0, 1'b1));
			else
				send_query(make_query(any_coord(), any_coord(), any_coord(),
					any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
					any_coord(), any_coord(), any_coord(), any_coord()));
		end
		@(negedge clk);
		pt_in.valid = 1'b0;

		// Drain, then give stray results a chance to show up
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d queries, %0d results: %0d within prism, %0d inside",
			sb.n_queries, sb.n_results, sb.n_prism, sb.n_inside);
		$display("%0d mismatches in %0d cycles", sb.n_errors, cycle_count);
		if (sb.n_errors == 0)
			$display("[point_in_triangle_3d_test] OK");
		else
			$display("[point_in_triangle_3d_test] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/pitt_pkg.sv
rtl/core/pitt_if.sv
rtl/core/pitt_side_test.sv
rtl/core/point_in_triangle_3d_test.sv
dv/tb_point_in_triangle_3d_test.sv
